/* rtl/wmal_pkg.sv */
// shared constants and types for the windowed mean absolute level block
`default_nettype none

package wmal_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 24;

  localparam int WL_W   = 11;
  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(1024);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_RUN  = 3'b010,
    BK_DONE = 3'b100
  } bk_state_t;

endpackage

`default_nettype wire

/* rtl/wmal_front.sv */
// front end: window register, magnitude, ring store and running sum
`default_nettype none

module wmal_front
  import wmal_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [WL_W-1:0]               cfg_wr_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          q_room,
  output logic                               q_push,
  output job_t                               q_job
);

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   wrapped_r, wrapped_nxt;
  logic                   busy_r, busy_nxt;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [LEN_W-1:0]       pos_inc;
  logic                   accept;

  function automatic logic [LEN_W-1:0] eff_len(input logic [WL_W-1:0] d);
    logic [LEN_W-1:0] r;
    if (d == '0) begin
      r = LEN_W'(1);
    end else if (32'(d) > MAX_WINDOW) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = LEN_W'(d);
    end
    return r;
  endfunction

  assign full   = busy_r | ~q_room;
  assign accept = push & ~full;

  assign mag     = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  assign old_val = wrapped_r ? rdata_r : '0;
  assign pos_inc = {1'b0, pos_r} + 1'b1;

  assign q_push = busy_r;
  assign q_job  = {sum_nxt, len_r};

  always_comb begin
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    wrapped_nxt = wrapped_r;
    busy_nxt    = accept;
    if (cfg_wr_en) begin
      len_nxt     = eff_len(cfg_wr_data);
      pos_nxt     = '0;
      sum_nxt     = '0;
      wrapped_nxt = 1'b0;
    end else if (busy_r) begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(mag_r);
      if (pos_inc >= len_r) begin
        pos_nxt     = '0;
        wrapped_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= eff_len(WL_RESET);
      pos_r     <= '0;
      sum_r     <= '0;
      wrapped_r <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      wrapped_r <= wrapped_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // ring store: read the entry being replaced on accept, write the new magnitude into it next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r   <= mag;
      rdata_r <= mem[pos_r];
    end
    if (busy_r) begin
      mem[pos_r] <= mag_r;
    end
  end

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("front busy longer than one cycle");

endmodule

`default_nettype wire

/* rtl/wmal_queue.sv */
// short job queue between front and back end
`default_nettype none

module wmal_queue
  import wmal_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      room,
  output logic      valid,
  input  wire logic rd_en,
  output job_t      rd_job
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room   = (cnt_r != QCNT_W'(QDEPTH));
  assign valid  = (cnt_r != '0);
  assign do_wr  = wr_en & room;
  assign do_rd  = rd_en & valid;
  assign rd_job = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr_r] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> room)
    else $error("job written into a full queue");

endmodule

`default_nettype wire

/* rtl/wmal_back.sv */
// back end: bit-serial restoring divide and result register
`default_nettype none

module wmal_back
  import wmal_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire job_t                    q_job,
  output logic                         q_pop,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [SAMPLE_BITS-1:0]       out_level
);

  bk_state_t              state_r, state_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [LEN_W-1:0]       div_r, div_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] lvl_r;
  logic [LEN_W-1:0]       trial;
  logic                   ge;
  logic                   take;
  logic                   load_out;

  assign empty     = ~ov_r;
  assign out_level = lvl_r;
  assign take      = pop & ov_r;

  assign trial = {rem_r[LEN_W-2:0], quo_r[SUM_W-1]};
  assign ge    = (trial >= div_r);

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          quo_nxt   = q_job.sum;
          div_nxt   = q_job.len;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        rem_nxt = ge ? (trial - div_r) : trial;
        quo_nxt = {quo_r[SUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ov_r || take) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (take) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (load_out) begin
      lvl_r <= quo_r[SAMPLE_BITS-1:0];
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN || state_r == BK_DONE) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (quo_r[SUM_W-1:SAMPLE_BITS] == '0))
    else $error("level quotient wider than sample");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> ov_r)
    else $error("result lost on load");

endmodule

`default_nettype wire

/* rtl/windowed_mean_abs_level_core.sv */
// top level of the windowed mean absolute level block
//
//  channel   handshake          payload
//  input     push / full        in_sample   (24 bit signed)
//  result    empty / pop        out_level   (24 bit unsigned)
//  config    cfg_wr_en          cfg_wr_data (11 bit window length)
//
// the divide produces one quotient bit per cycle over the 34 bit running sum;
// the front accepts new samples into the job queue while a divide runs, until the queue is full
// front handles each item as a ring store read, then the store write and sum update
// synchronous active-low reset; store entries count as zero until the ring wraps
// a finished result waits in the output register while the next one is divided
`default_nettype none

module windowed_mean_abs_level_core
  import wmal_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [WL_W-1:0]               cfg_wr_data,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [SAMPLE_BITS-1:0]             out_level
);

  job_t fq_job;
  job_t qb_job;
  logic fq_push;
  logic q_room;
  logic q_valid;
  logic q_pop;

  wmal_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .in_sample  (in_sample),
    .q_room     (q_room),
    .q_push     (fq_push),
    .q_job      (fq_job)
  );

  wmal_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (fq_push),
    .wr_job(fq_job),
    .room  (q_room),
    .valid (q_valid),
    .rd_en (q_pop),
    .rd_job(qb_job)
  );

  wmal_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (qb_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_level(out_level)
  );

endmodule

`default_nettype wire

/* dv/wmal_level_checker.sv */
// checker for the windowed mean absolute level block: predicts each level and compares it
`timescale 1ns / 100ps

module wmal_level_checker
  import wmal_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [WL_W-1:0]               cfg_wr_data,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [SAMPLE_BITS-1:0]        out_level,
  output int                            err_count,
  output int                            pending
);

  logic [WL_W-1:0]        win_len;
  logic [SAMPLE_BITS-1:0] mag_ring [MAX_WINDOW];
  int unsigned            ring_pos;
  logic [SUM_W-1:0]       mag_total;
  logic [SAMPLE_BITS-1:0] levels_due [$];
  logic [SAMPLE_BITS-1:0] want;
  int                     errs = 0;

  function automatic int unsigned span_of(logic [WL_W-1:0] wl);
    if (wl == '0) return 1;
    if (wl > MAX_WINDOW) return MAX_WINDOW;
    return wl;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) mag_ring[i] = '0;
    ring_pos  = 0;
    mag_total = '0;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] predict_level(logic signed [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    int unsigned            span;
    int unsigned            slot;
    raw  = s;
    mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    span = span_of(win_len);
    slot = (ring_pos >= span) ? 0 : ring_pos;
    mag_total = mag_total - mag_ring[slot] + mag;
    mag_ring[slot] = mag;
    slot++;
    if (slot >= span) slot = 0;
    ring_pos = slot;
    return SAMPLE_BITS'(mag_total / span);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = WL_RESET;
      clear_window();
      levels_due.delete();
    end else begin
      if (cfg_wr_en) begin
        win_len = cfg_wr_data;
        clear_window();
      end
      if (pop && !empty) begin
        if (levels_due.size() == 0) begin
          if (errs < 10) $display("%0t: level %0d transferred with none expected", $time, out_level);
          errs++;
        end else begin
          want = levels_due.pop_front();
          if (out_level !== want) begin
            if (errs < 10) begin
              $display("%0t: level mismatch: expected %0d, got %0d", $time, want, out_level);
            end
            errs++;
          end
        end
      end
      if (push && !full) levels_due.push_back(predict_level(in_sample));
    end
    pending   <= levels_due.size();
    err_count <= errs;
  end

endmodule

/* dv/testbench.sv */
// testbench top: clock, reset, stimulus and verdict for windowed_mean_abs_level_core
`timescale 1ns / 100ps

module testbench;
  import wmal_pkg::*;

  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int LONG_ITEMS     = 1060;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [WL_W-1:0]               WL_TOP     = '1;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          cfg_wr_en   = 1'b0;
  logic [WL_W-1:0]               cfg_wr_data = '0;
  logic                          push        = 1'b0;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] in_sample   = '0;
  logic                          empty;
  logic                          pop         = 1'b0;
  logic [SAMPLE_BITS-1:0]        out_level;

  int err_count;
  int pending;
  int cycles     = 0;
  int hold_reqs  = 0;
  int holds_done = 0;
  bit steady     = 1'b0;

  windowed_mean_abs_level_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .full        (full),
    .in_sample   (in_sample),
    .empty       (empty),
    .pop         (pop),
    .out_level   (out_level)
  );

  wmal_level_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .full        (full),
    .in_sample   (in_sample),
    .empty       (empty),
    .pop         (pop),
    .out_level   (out_level),
    .err_count   (err_count),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          3: return '1;
          default: return SAMPLE_BITS'(1);
        endcase
      end
      1, 2: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    push      <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : draw_gap();
    if (gap > 0) begin
      push      <= 1'b0;
      in_sample <= SAMPLE_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_window(input logic [WL_W-1:0] wl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= wl;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : rx_side
    int gap;
    int hold;
    gap  = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold = RX_HOLD_CYCLES;
      end
      if (gap == 0 && !steady && $urandom_range(0, 7) == 0) gap = draw_gap();
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [WL_W-1:0] wl;
    int              n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 1024
    send(SAMPLE_MAX);
    send(SAMPLE_MIN);
    send('1);
    send(SAMPLE_BITS'(1));
    send('0);
    drain();

    // zero acts as a window of one
    load_window('0);
    send(SAMPLE_MIN);
    send(SAMPLE_MAX);
    send('1);
    send(SAMPLE_BITS'(1));
    send('0);
    drain();

    // ramp up, then wrap
    load_window(WL_W'(3));
    repeat (3) send(SAMPLE_MAX);
    repeat (3) send(SAMPLE_MIN);
    send('0);
    drain();

    load_window(WL_W'(1));
    send(SAMPLE_MIN);
    send(SAMPLE_BITS'(-3));
    drain();

    // saturates at the largest window
    load_window(WL_TOP);
    send(SAMPLE_MIN);
    send(SAMPLE_MAX);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: wl = WL_W'(1);
        1: wl = WL_W'(2);
        2: wl = WL_W'(5);
        3: wl = WL_W'(16);
        4: wl = '0;
        5: wl = WL_W'($urandom_range(1, 64));
        6: wl = WL_W'($urandom_range(0, 2047));
        7: wl = WL_W'(7);
        default: wl = WL_W'(1025);
      endcase
      load_window(wl);
      steady <= (p == 7);
      n = $urandom_range(15, 25);
      repeat (n) send(pick_sample());
      drain();
    end
    steady <= 1'b0;

    // long run at the full window so the ring wraps at its last entry
    load_window(WL_RESET);
    for (int i = 0; i < LONG_ITEMS; i++) begin
      if (i == 200) hold_reqs <= hold_reqs + 1;
      if (i == 500) steady <= 1'b1;
      if (i == 700) steady <= 1'b0;
      if (i == 800) drain();
      send(pick_sample());
    end
    drain();

    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/wmal_pkg.sv
rtl/wmal_front.sv
rtl/wmal_queue.sv
rtl/wmal_back.sv
rtl/windowed_mean_abs_level_core.sv
dv/wmal_level_checker.sv
dv/testbench.sv
